// ----- design/pvw_pkg.sv -----
package pvw_pkg;

    // Default table depth.
    localparam int PVW_SLOTS = 16;

    // Number of inhibit levels held in the table.
    localparam int LEVELS = 3;

    localparam int ID_W      = 16;
    localparam int REQ_W     = 3;
    localparam int MODE_W    = 2;
    localparam int TIMEOUT_W = 16;

    typedef logic [1:0]           opcode_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [ID_W-1:0]      req_id_t;
    typedef logic [TIMEOUT_W-1:0] seconds_t;

    // Transaction opcodes.
    localparam opcode_t OP_SET  = 2'd0;
    localparam opcode_t OP_TERM = 2'd1;
    localparam opcode_t OP_TICK = 2'd2;

    // Announced mode and vote level codes.
    localparam mode_t MODE_ENABLE    = 2'd0;
    localparam mode_t MODE_DISABLE   = 2'd1;
    localparam mode_t MODE_LIGHT_OFF = 2'd2;
    localparam mode_t MODE_SUSPEND   = 2'd3;

    // Command from the mode controller to the slot table.
    typedef struct packed {
        logic    drop;
        logic    store;
        logic    clear_all;
        req_id_t id;
        mode_t   level;
    } slot_cmd_t;

    // Table status, computed on the updated contents.
    typedef struct packed {
        logic              dropped;
        logic              full;
        logic [LEVELS-1:0] present;
    } slot_stat_t;

    // One result transaction.
    typedef struct packed {
        mode_t mode;
        logic  mode_changed;
        logic  force_suspend;
        logic  table_full;
        logic  unknown_mode;
    } result_t;

endpackage

// ----- design/pvw_item_if.sv -----
interface pvw_item_if import pvw_pkg::*; ();

    logic    valid;
    logic    ready;
    opcode_t opcode;
    req_id_t requester_id;
    logic [REQ_W-1:0] requested_mode;

    modport source (
        output valid,
        output opcode,
        output requester_id,
        output requested_mode,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  requester_id,
        input  requested_mode,
        output ready
    );

endinterface

// ----- design/pvw_result_if.sv -----
interface pvw_result_if import pvw_pkg::*; ();

    logic  valid;
    logic  ready;
    mode_t mode;
    logic  mode_changed;
    logic  force_suspend;
    logic  table_full;
    logic  unknown_mode;

    modport source (
        output valid,
        output mode,
        output mode_changed,
        output force_suspend,
        output table_full,
        output unknown_mode,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  mode_changed,
        input  force_suspend,
        input  table_full,
        input  unknown_mode,
        output ready
    );

endinterface

// ----- design/pvw_slot_table.sv -----
module pvw_slot_table import pvw_pkg::*;
#(
    parameter int SLOTS = PVW_SLOTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_cmd_t  cmd,
    output slot_stat_t stat
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    req_id_t          id_reg  [SLOTS];
    mode_t            lvl_reg [SLOTS];

    logic [SLOTS-1:0] hit_l1;
    logic [SLOTS-1:0] hit_l2;
    logic [SLOTS-1:0] hit_l3;
    logic [SLOTS-1:0] drop_vec;
    logic [SLOTS-1:0] valid_mid;
    logic [SLOTS-1:0] ins_vec;
    logic [SLOTS-1:0] lvl1_vec;
    logic [SLOTS-1:0] lvl2_vec;
    logic [SLOTS-1:0] lvl3_vec;

    // Isolates the lowest set bit of a slot vector.
    function automatic logic [SLOTS-1:0] lowest_one(input logic [SLOTS-1:0] v);
        return v & (~v + SLOTS'(1));
    endfunction

    // Id match over all slots, split by level for the priority search.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_l1[i] = valid_reg[i] && (id_reg[i] == cmd.id) && (lvl_reg[i] == MODE_DISABLE);
            hit_l2[i] = valid_reg[i] && (id_reg[i] == cmd.id)
                        && (lvl_reg[i] == MODE_LIGHT_OFF);
            hit_l3[i] = valid_reg[i] && (id_reg[i] == cmd.id) && (lvl_reg[i] == MODE_SUSPEND);
        end
    end

    // Drop the old vote, then place the new one in the lowest free slot; a clear empties every slot.
    always_comb
    begin
        if (!cmd.drop)
        begin
            drop_vec = '0;
        end
        else if (|hit_l1)
        begin
            drop_vec = lowest_one(hit_l1);
        end
        else if (|hit_l2)
        begin
            drop_vec = lowest_one(hit_l2);
        end
        else
        begin
            drop_vec = lowest_one(hit_l3);
        end

        valid_mid = valid_reg & ~drop_vec;
        ins_vec   = cmd.store ? lowest_one(~valid_mid) : '0;

        if (cmd.clear_all)
        begin
            valid_next = '0;
        end
        else
        begin
            valid_next = valid_mid | ins_vec;
        end
    end

    // Level summary of the updated table.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            lvl1_vec[i] = ins_vec[i] ? (cmd.level == MODE_DISABLE)
                                     : (lvl_reg[i] == MODE_DISABLE);
            lvl2_vec[i] = ins_vec[i] ? (cmd.level == MODE_LIGHT_OFF)
                                     : (lvl_reg[i] == MODE_LIGHT_OFF);
            lvl3_vec[i] = ins_vec[i] ? (cmd.level == MODE_SUSPEND)
                                     : (lvl_reg[i] == MODE_SUSPEND);
        end
        stat.dropped    = |drop_vec;
        stat.full       = cmd.store && !(|ins_vec);
        stat.present[0] = |(valid_next & lvl1_vec);
        stat.present[1] = |(valid_next & lvl2_vec);
        stat.present[2] = |(valid_next & lvl3_vec);
    end

    // Slot valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot payload is only read behind its valid bit.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (ins_vec[i])
            begin
                id_reg[i]  <= cmd.id;
                lvl_reg[i] <= cmd.level;
            end
        end
    end

`ifndef SYNTHESIS
    a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ins_vec))
        else $error("more than one slot written");

    a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ins_vec & valid_mid) == '0)
        else $error("vote stored into an occupied slot");

    a_drop_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (drop_vec & ~valid_reg) == '0)
        else $error("vote dropped from an empty slot");
`endif

endmodule

// ----- design/pvw_mode_ctrl.sv -----
module pvw_mode_ctrl import pvw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  opcode_t          opcode,
    input  req_id_t          requester_id,
    input  logic [REQ_W-1:0] requested_mode,
    input  seconds_t         timeout_seconds,
    input  slot_stat_t       stat,
    output slot_cmd_t        cmd,
    output result_t          res
);

    mode_t    mode_reg;
    mode_t    mode_next;
    logic     run_reg;
    logic     run_next;
    seconds_t left_reg;
    seconds_t left_next;

    logic  known_req;
    logic  expire;
    logic  do_reeval;
    mode_t best;

    // Decode the transaction into a table command.
    always_comb
    begin
        known_req = (requested_mode[REQ_W-1] == 1'b0);
        expire    = (opcode == OP_TICK) && run_reg && (left_reg[TIMEOUT_W-1:1] == '0);

        cmd.drop      = fire && ((opcode == OP_SET) || (opcode == OP_TERM));
        cmd.store     = fire && (opcode == OP_SET) && known_req
                        && (requested_mode[MODE_W-1:0] != MODE_ENABLE);
        cmd.clear_all = fire && expire;
        cmd.id        = requester_id;
        cmd.level     = requested_mode[MODE_W-1:0];
    end

    // Highest-priority level still holding a vote.
    always_comb
    begin
        if (stat.present[0])
        begin
            best = MODE_DISABLE;
        end
        else if (stat.present[1])
        begin
            best = MODE_LIGHT_OFF;
        end
        else if (stat.present[2])
        begin
            best = MODE_SUSPEND;
        end
        else
        begin
            best = MODE_ENABLE;
        end
    end

    // Mode re-evaluation and watchdog update.
    always_comb
    begin
        mode_next         = mode_reg;
        run_next          = run_reg;
        left_next         = left_reg;
        do_reeval         = 1'b0;
        res.force_suspend = 1'b0;
        res.unknown_mode  = 1'b0;
        res.table_full    = stat.full;

        case (opcode)
            OP_SET:
            begin
                if (known_req)
                begin
                    do_reeval = 1'b1;
                end
                else
                begin
                    res.unknown_mode = 1'b1;
                end
            end
            OP_TERM:
            begin
                do_reeval = stat.dropped;
            end
            OP_TICK:
            begin
                if (expire)
                begin
                    mode_next         = MODE_ENABLE;
                    run_next          = 1'b0;
                    left_next         = '0;
                    res.force_suspend = 1'b1;
                end
                else if (run_reg)
                begin
                    left_next = left_reg - seconds_t'(1);
                end
            end
            default:
            begin
                do_reeval = 1'b0;
            end
        endcase

        if (do_reeval && (best != mode_reg))
        begin
            if (mode_reg == MODE_ENABLE)
            begin
                if (timeout_seconds != '0)
                begin
                    run_next  = 1'b1;
                    left_next = timeout_seconds;
                end
            end
            else if (best == MODE_ENABLE)
            begin
                run_next = 1'b0;
            end
            mode_next = best;
        end

        res.mode         = mode_next;
        res.mode_changed = (mode_next != mode_reg);
    end

    // Mode and watchdog registers advance once per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENABLE;
            run_reg  <= 1'b0;
            left_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            run_reg  <= run_next;
            left_reg <= left_next;
        end
    end

`ifndef SYNTHESIS
    a_run_inhibit: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (mode_reg != MODE_ENABLE))
        else $error("watchdog running while mode is enable");

    a_force_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.force_suspend) |=> (mode_reg == MODE_ENABLE) && !run_reg)
        else $error("forced suspend left an inhibit in place");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg) && $stable(run_reg) && $stable(left_reg))
        else $error("state moved without a transaction");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(res.table_full && res.unknown_mode))
        else $error("table full and unknown mode on one transaction");
`endif

endmodule

// ----- design/power_mode_vote_watchdog_unit.sv -----
// Channel   Direction  Payload
// item      in         opcode, requester_id, requested_mode
// result    out        mode, mode_changed, force_suspend, table_full, unknown_mode
// cfg       in         cfg_wr_en, cfg_wr_data (timeout_seconds)
//
// Each transaction is taken into an input register and settled by a parallel id match
// over all slots; its result then goes into the result register and is offered from there.
// One transaction is accepted per cycle while the result channel is not stalled; the result register
// and input register form a two-entry pipeline, so a stalled result still lets one more item in.
// Reset clears the slot valid bits, the mode, the watchdog and the timeout at once.
module power_mode_vote_watchdog_unit import pvw_pkg::*;
#(
    parameter int SLOTS = PVW_SLOTS
)
(
    input  logic           clk,
    input  logic           rst_n,
    pvw_item_if.sink       item,
    pvw_result_if.source   result,
    input  logic           cfg_wr_en,
    input  seconds_t       cfg_wr_data
);

    logic             in_vld_reg;
    logic             in_vld_next;
    opcode_t          op_reg;
    req_id_t          id_reg;
    logic [REQ_W-1:0] req_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    result_t          res_reg;
    seconds_t         timeout_reg;

    logic       fire;
    logic       take;
    slot_cmd_t  cmd;
    slot_stat_t stat;
    result_t    res;

    // Handshake control.
    always_comb
    begin
        fire         = in_vld_reg && (!out_vld_reg || result.ready);
        item.ready   = !in_vld_reg || fire;
        take         = item.valid && item.ready;
        in_vld_next  = take || (in_vld_reg && !fire);
        out_vld_next = fire || (out_vld_reg && !result.ready);
    end

    // Control registers and timeout.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            timeout_reg <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= item.opcode;
            id_reg  <= item.requester_id;
            req_reg <= item.requested_mode;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    pvw_mode_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .opcode          (op_reg),
        .requester_id    (id_reg),
        .requested_mode  (req_reg),
        .timeout_seconds (timeout_reg),
        .stat            (stat),
        .cmd             (cmd),
        .res             (res)
    );

    pvw_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Result channel.
    assign result.valid         = out_vld_reg;
    assign result.mode          = res_reg.mode;
    assign result.mode_changed  = res_reg.mode_changed;
    assign result.force_suspend = res_reg.force_suspend;
    assign result.table_full    = res_reg.table_full;
    assign result.unknown_mode  = res_reg.unknown_mode;

`ifndef SYNTHESIS
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !result.ready) |=> out_vld_reg)
        else $error("result transaction lost under stall");

    a_fire_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_vld_reg)
        else $error("processed transaction produced no result");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !fire) |=> in_vld_reg && $stable(op_reg) && $stable(id_reg))
        else $error("pending transaction overwritten");
`endif

endmodule
